// ----- sv/bgpio_pkg.sv -----
// ----------------------------------------------------------------------------
// bgpio_pkg
// Shared types and constants of the banked GPIO register block: item kinds,
// register kinds, the per-bank state entry and the packed result layout.
// ----------------------------------------------------------------------------
package bgpio_pkg;

  // Defaults of the top-level parameters
  localparam int BGPIO_NUM_BANKS    = 6;
  localparam int BGPIO_NARROW_BANKS = 3;
  localparam int BGPIO_NARROW_WIDTH = 26;

  // Masked data registers split a bank into two halves of this many pins
  localparam int HalfWidth = 16;

  // Field widths
  localparam int DataW = 32;
  localparam int AddrW = 10;
  localparam int BankW = 3;
  localparam int FuncW = 2;

  // Stream payload widths, padded to whole bytes
  localparam int InFieldsW  = AddrW + DataW + BankW + DataW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = DataW + BankW + DataW + DataW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Register map
  localparam logic [AddrW-1:0] MaskRegionEnd  = 10'h040;
  localparam logic [AddrW-1:0] DataRegionEnd  = 10'h060;
  localparam logic [AddrW-1:0] InputRegionEnd = 10'h080;
  localparam logic [AddrW-1:0] DirBase        = 10'h204;
  localparam logic [5:0]       DirOffset      = 6'h00;
  localparam logic [5:0]       OenOffset      = 6'h04;

  typedef enum logic [FuncW-1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_NONE    = 3'd0,
    REG_MASK_LO = 3'd1,
    REG_MASK_HI = 3'd2,
    REG_DATA    = 3'd3,
    REG_INPUT   = 3'd4,
    REG_DIR     = 3'd5,
    REG_OEN     = 3'd6
  } reg_kind_t;

  // Address decode result
  typedef struct packed {
    logic             hit;
    reg_kind_t        kind;
    logic [BankW-1:0] bank;
  } dec_t;

  // Per-bank state, one memory entry
  typedef struct packed {
    logic [DataW-1:0] in_lvl;
    logic [DataW-1:0] oen;
    logic [DataW-1:0] dir;
    logic [DataW-1:0] out_val;
  } bank_entry_t;

  // Result fields, last field in the lowest bits
  typedef struct packed {
    logic [DataW-1:0] bank_drive_enable;
    logic [DataW-1:0] bank_drive;
    logic [BankW-1:0] touched_bank;
    logic [DataW-1:0] read_data;
  } res_t;

endpackage

// ----- sv/bgpio_decode.sv -----
// ----------------------------------------------------------------------------
// bgpio_decode
// Register address decode: register kind and bank of a byte offset.
// ----------------------------------------------------------------------------
module bgpio_decode #(
  parameter int NUM_BANKS = bgpio_pkg::BGPIO_NUM_BANKS
) (
  input  logic [bgpio_pkg::AddrW-1:0] address,
  output bgpio_pkg::dec_t             dec
);
  import bgpio_pkg::*;

  logic [AddrW-1:0] dir_off;
  reg_kind_t        kind;
  logic [BankW-1:0] bank;

  assign dir_off = address - DirBase;

  always_comb begin
    kind = REG_NONE;
    bank = '0;
    if (address[1:0] == 2'b00) begin
      if (address < MaskRegionEnd) begin
        bank = address[5:3];
        kind = address[2] ? REG_MASK_HI : REG_MASK_LO;
      end else if (address < DataRegionEnd) begin
        bank = address[4:2];
        kind = REG_DATA;
      end else if (address < InputRegionEnd) begin
        bank = address[4:2];
        kind = REG_INPUT;
      end else if (address >= DirBase) begin
        bank = dir_off[8:6];
        if (dir_off[5:0] == DirOffset) begin
          kind = REG_DIR;
        end else if (dir_off[5:0] == OenOffset) begin
          kind = REG_OEN;
        end
      end
    end
  end

  always_comb begin
    dec.bank = bank;
    dec.hit  = (kind != REG_NONE) && ({1'b0, bank} < (BankW + 1)'(NUM_BANKS));
    dec.kind = dec.hit ? kind : REG_NONE;
  end

endmodule

// ----- sv/bgpio_bank_ram.sv -----
// ----------------------------------------------------------------------------
// bgpio_bank_ram
// Per-bank state memory, one entry per bank, registered read. Valid bits
// make an entry read as zero until its first write after reset.
// ----------------------------------------------------------------------------
module bgpio_bank_ram #(
  parameter int NUM_BANKS = bgpio_pkg::BGPIO_NUM_BANKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [bgpio_pkg::BankW-1:0] rd_bank,
  output bgpio_pkg::bank_entry_t      rd_data,
  input  logic                        wr_en,
  input  logic [bgpio_pkg::BankW-1:0] wr_bank,
  input  bgpio_pkg::bank_entry_t      wr_data
);
  import bgpio_pkg::*;

  localparam int IdxW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  bank_entry_t            mem [NUM_BANKS];
  logic [NUM_BANKS-1:0]   vld_r;
  bank_entry_t            rd_data_r;
  logic                   rd_vld_r;
  logic [IdxW-1:0]        rd_idx;
  logic [IdxW-1:0]        wr_idx;

  assign rd_idx = rd_bank[IdxW-1:0];
  assign wr_idx = wr_bank[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- sv/bgpio_update.sv -----
// ----------------------------------------------------------------------------
// bgpio_update
// Modify step: applies a read, write or pin sample to one bank entry and
// forms the result fields.
// ----------------------------------------------------------------------------
module bgpio_update #(
  parameter int NARROW_BANKS = bgpio_pkg::BGPIO_NARROW_BANKS,
  parameter int NARROW_WIDTH = bgpio_pkg::BGPIO_NARROW_WIDTH
) (
  input  bgpio_pkg::func_t             func,
  input  bgpio_pkg::reg_kind_t         kind,
  input  logic [bgpio_pkg::BankW-1:0]  bank,
  input  logic                         touched,
  input  logic [bgpio_pkg::DataW-1:0]  write_data,
  input  logic [bgpio_pkg::DataW-1:0]  pin_levels,
  input  bgpio_pkg::bank_entry_t       cur,
  output bgpio_pkg::bank_entry_t       nxt,
  output bgpio_pkg::res_t              res
);
  import bgpio_pkg::*;

  localparam logic [DataW-1:0] NarrowMask = (NARROW_WIDTH >= DataW) ? '1 :
    DataW'((64'd1 << NARROW_WIDTH) - 64'd1);

  logic [DataW-1:0] wmask;
  logic [DataW-1:0] upd_lo;
  logic [DataW-1:0] dat_lo;
  logic [DataW-1:0] upd_hi;
  logic [DataW-1:0] dat_hi;
  logic [DataW-1:0] rdata;

  assign wmask  = ({1'b0, bank} < (BankW + 1)'(NARROW_BANKS)) ? NarrowMask : '1;
  assign upd_lo = {{HalfWidth{1'b0}}, ~write_data[DataW-1:HalfWidth]};
  assign dat_lo = {{HalfWidth{1'b0}}, write_data[HalfWidth-1:0]};
  assign upd_hi = {~write_data[DataW-1:HalfWidth], {HalfWidth{1'b0}}};
  assign dat_hi = {write_data[HalfWidth-1:0], {HalfWidth{1'b0}}};

  always_comb begin
    nxt   = cur;
    rdata = '0;
    case (func)
      FUNC_READ: begin
        case (kind)
          REG_MASK_LO: rdata = {{HalfWidth{1'b0}}, cur.out_val[HalfWidth-1:0]};
          REG_MASK_HI: rdata = {{HalfWidth{1'b0}}, cur.out_val[DataW-1:HalfWidth]};
          REG_DATA:    rdata = cur.out_val;
          REG_INPUT:   rdata = cur.in_lvl;
          REG_DIR:     rdata = cur.dir;
          REG_OEN:     rdata = cur.oen;
          default:     rdata = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (kind)
          REG_MASK_LO: nxt.out_val = ((cur.out_val & ~upd_lo) | (dat_lo & upd_lo)) & wmask;
          REG_MASK_HI: nxt.out_val = ((cur.out_val & ~upd_hi) | (dat_hi & upd_hi)) & wmask;
          REG_DATA:    nxt.out_val = write_data & wmask;
          REG_DIR:     nxt.dir     = write_data & wmask;
          REG_OEN:     nxt.oen     = write_data & wmask;
          default:     nxt         = cur;
        endcase
      end
      FUNC_SAMPLE: nxt.in_lvl = pin_levels & wmask;
      default:     nxt = cur;
    endcase
  end

  always_comb begin
    res = '0;
    if (touched) begin
      res.read_data         = rdata;
      res.touched_bank      = bank;
      res.bank_drive        = nxt.out_val;
      res.bank_drive_enable = nxt.dir & nxt.oen;
    end
  end

endmodule

// ----- sv/banked_gpio_register_block.sv -----
// ----------------------------------------------------------------------------
// banked_gpio_register_block
// Banked GPIO controller behind 32-bit registers: register reads, masked and
// plain register writes, and pin-level samples, one bank per request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------
//  in_      | in  | in_tvalid/in_tready  | tuser func, tdata address..levels
//  out_     | out | out_tvalid/out_tready| tuser addr_error, tdata result
//
//  A request is handled in the accept cycle, which issues the read of the
//  bank entry, and in the modify cycle after it, which modifies the entry,
//  writes it back and loads the result register. The registered read of the
//  bank memory sets this split; in_tready is low during the modify cycle, so
//  a read never meets a pending write-back of the same entry.
//  A stalled result holds the modify cycle until out_tready frees the
//  result register; a new request is taken as soon as the result is loaded.
//  Reset clears the control state and the entry valid bits; every bank then
//  reads as zero until written, no clearing pass is needed.
// ----------------------------------------------------------------------------
module banked_gpio_register_block #(
  parameter int NUM_BANKS    = bgpio_pkg::BGPIO_NUM_BANKS,
  parameter int NARROW_BANKS = bgpio_pkg::BGPIO_NARROW_BANKS,
  parameter int NARROW_WIDTH = bgpio_pkg::BGPIO_NARROW_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [9:0] address, [41:10] write_data, [44:42] sample_bank,
  // [76:45] pin_levels, [79:77] zero
  input  logic [bgpio_pkg::InDataW-1:0]  in_tdata,
  // [1:0] func
  input  logic [bgpio_pkg::FuncW-1:0]    in_tuser,
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] read_data, [34:32] touched_bank, [66:35] bank_drive,
  // [98:67] bank_drive_enable, [103:99] zero
  output logic [bgpio_pkg::OutDataW-1:0] out_tdata,
  // [0] addr_error
  output logic                           out_tuser
);
  import bgpio_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Unpacked request fields
  logic [AddrW-1:0] in_address;
  logic [DataW-1:0] in_write_data;
  logic [BankW-1:0] in_sample_bank;
  logic [DataW-1:0] in_pin_levels;
  func_t            in_func;

  assign in_address     = in_tdata[AddrW-1:0];
  assign in_write_data  = in_tdata[AddrW+DataW-1:AddrW];
  assign in_sample_bank = in_tdata[AddrW+DataW+BankW-1:AddrW+DataW];
  assign in_pin_levels  = in_tdata[InFieldsW-1:AddrW+DataW+BankW];
  assign in_func        = func_t'(in_tuser);

  state_t           state_r, state_nxt;
  func_t            func_r;
  reg_kind_t        kind_r;
  logic [BankW-1:0] bank_r;
  logic             touch_r;
  logic             err_r;
  logic [DataW-1:0] wdata_r;
  logic [DataW-1:0] levels_r;
  logic             out_tvalid_r, out_tvalid_nxt;
  res_t             out_res_r;
  logic             out_err_r;

  dec_t             dec;
  logic             acc;
  logic             is_reg;
  logic             touch_new;
  logic [BankW-1:0] bank_new;
  logic             go;
  logic             wr_en;
  bank_entry_t      cur_entry;
  bank_entry_t      nxt_entry;
  res_t             res;

  bgpio_decode #(
    .NUM_BANKS (NUM_BANKS)
  ) u_decode (
    .address (in_address),
    .dec     (dec)
  );

  // Decide at accept time whether the request touches a bank, and which
  assign acc    = in_tvalid && in_tready;
  assign is_reg = (in_func == FUNC_READ) || (in_func == FUNC_WRITE);

  always_comb begin
    touch_new = 1'b0;
    bank_new  = dec.bank;
    if (is_reg) begin
      touch_new = dec.hit;
    end else if (in_func == FUNC_SAMPLE) begin
      bank_new  = in_sample_bank;
      touch_new = {1'b0, in_sample_bank} < (BankW + 1)'(NUM_BANKS);
    end
  end

  bgpio_bank_ram #(
    .NUM_BANKS (NUM_BANKS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc && touch_new),
    .rd_bank (bank_new),
    .rd_data (cur_entry),
    .wr_en   (wr_en),
    .wr_bank (bank_r),
    .wr_data (nxt_entry)
  );

  bgpio_update #(
    .NARROW_BANKS (NARROW_BANKS),
    .NARROW_WIDTH (NARROW_WIDTH)
  ) u_update (
    .func       (func_r),
    .kind       (kind_r),
    .bank       (bank_r),
    .touched    (touch_r),
    .write_data (wdata_r),
    .pin_levels (levels_r),
    .cur        (cur_entry),
    .nxt        (nxt_entry),
    .res        (res)
  );

  // Advance out of the modify cycle only when the result register is free
  assign go    = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);
  // Write back only what can change state; reads leave the entry alone
  assign wr_en = go && touch_r && ((func_r == FUNC_WRITE) || (func_r == FUNC_SAMPLE));

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Hold the request for the modify cycle; load the result on advance
  always_ff @(posedge clk) begin
    if (acc) begin
      func_r   <= in_func;
      kind_r   <= dec.kind;
      bank_r   <= bank_new;
      touch_r  <= touch_new;
      err_r    <= is_reg && !dec.hit;
      wdata_r  <= in_write_data;
      levels_r <= in_pin_levels;
    end
    if (go) begin
      out_res_r <= res;
      out_err_r <= err_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OutDataW - OutFieldsW)'(0), out_res_r};
  assign out_tuser  = out_err_r;

`ifndef SYNTH
  // The memory port never reads and writes back in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && acc))
    else $error("bank memory read and write-back overlap");

  // A new result appears only right after a modify cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_EXEC))
    else $error("result loaded without a modify cycle");

  // An address error carries an all-zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("address error with nonzero result fields");

  // A stalled result holds the pending request in the modify cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_tvalid_r && !out_tready |=> state_r == S_EXEC)
    else $error("modify cycle left while the result register was full");

  // A sample never reports an address error
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_func == FUNC_SAMPLE) |=> !err_r)
    else $error("sample request flagged as address error");
`endif

endmodule
